### hw/rtl/gamepad_report_conditioner_unit_assert.svh
// Assertion macros used by the report conditioner top level
`ifndef GAMEPAD_REPORT_CONDITIONER_UNIT_ASSERT_SVH
`define GAMEPAD_REPORT_CONDITIONER_UNIT_ASSERT_SVH

// Same-cycle implication under a reset guard
`define GRC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a reset guard
`define GRC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/grc_pkg.sv
// Shared types, constants and helpers of the report conditioner
package grc_pkg;

  localparam int AXW       = 16;
  localparam int MAGW      = 15;
  localparam int NUMW      = 2 * MAGW;
  localparam int DIV_STEPS = MAGW;
  // stage 0 front, stages 1..DIV_STEPS divide, last stage output register
  localparam int PIPE_LAST = DIV_STEPS + 1;

  localparam logic [MAGW-1:0] AXIS_FULL    = 15'd32767;
  localparam logic [MAGW-1:0] DZ_CAP       = 15'd32766;
  localparam logic [59:0]     MAP_IDENTITY = 60'hFEDCA9876543210;

  // register indexes
  localparam logic [1:0] REG_FLAGS = 2'd0;
  localparam logic [1:0] REG_DZ_L  = 2'd1;
  localparam logic [1:0] REG_DZ_R  = 2'd2;
  localparam logic [1:0] REG_MAP   = 2'd3;

  // stick_flags bit positions
  localparam int F_INV_LX = 0;
  localparam int F_INV_LY = 1;
  localparam int F_INV_RX = 2;
  localparam int F_INV_RY = 3;
  localparam int F_RAD_L  = 4;
  localparam int F_RAD_R  = 5;
  localparam int F_SCL_L  = 6;
  localparam int F_SCL_R  = 7;
  localparam int F_SWAP   = 8;

  typedef enum logic [1:0] {
    AM_PASS  = 2'd0,
    AM_ZERO  = 2'd1,
    AM_SCALE = 2'd2
  } axis_mode_t;

  typedef struct packed {
    axis_mode_t       mode;
    logic [AXW-1:0]   val;   // post-inversion value, sign in top bit
  } axis_info_t;

  typedef struct packed {
    axis_info_t [3:0] ax;    // 0 LX, 1 LY, 2 RX, 3 RY
    logic [15:0]      buttons;
    logic             swap;
  } grc_side_t;

  // source button of map nibble i (bit 11 is skipped)
  function automatic logic [3:0] map_src(input logic [3:0] i);
    map_src = (i < 4'd11) ? i : i + 4'd1;
  endfunction

endpackage

### hw/rtl/grc_stick.sv
// Deadzone decision and divide operands for one stick
module grc_stick (
  input  logic [grc_pkg::AXW-1:0]  x,
  input  logic [grc_pkg::AXW-1:0]  y,
  input  logic [grc_pkg::MAGW-1:0] dz,
  input  logic                     radial,
  input  logic                     scale,
  output grc_pkg::axis_info_t      ax_x,
  output grc_pkg::axis_info_t      ax_y,
  output logic [grc_pkg::NUMW-1:0] num_x,
  output logic [grc_pkg::NUMW-1:0] num_y,
  output logic [grc_pkg::MAGW-1:0] divisor
);
  import grc_pkg::*;

  logic [MAGW-1:0] dzc, mx, my, dfx, dfy;
  logic            ltx, lty, gtx, gty;
  axis_mode_t      mdx, mdy;

  // capped deadzone and magnitudes
  assign dzc = (dz == AXIS_FULL) ? DZ_CAP : dz;
  assign mx  = x[AXW-1] ? ~x[MAGW-1:0] : x[MAGW-1:0];
  assign my  = y[AXW-1] ? ~y[MAGW-1:0] : y[MAGW-1:0];
  assign ltx = mx < dzc;
  assign lty = my < dzc;
  assign gtx = mx > dzc;
  assign gty = my > dzc;

  // per-axis outcome
  always_comb begin
    mdx = AM_PASS;
    mdy = AM_PASS;
    if (dz != '0) begin
      if (radial) begin
        if (ltx && lty) begin
          mdx = AM_ZERO;
          mdy = AM_ZERO;
        end else if (scale) begin
          mdx = gtx ? AM_SCALE : AM_ZERO;
          mdy = gty ? AM_SCALE : AM_ZERO;
        end
      end else begin
        if (ltx) mdx = AM_ZERO;
        else if (scale) mdx = AM_SCALE;
        if (lty) mdy = AM_ZERO;
        else if (scale) mdy = AM_SCALE;
      end
    end
  end

  // 32767 * (mag - dz) as a shift and subtract
  assign dfx     = mx - dzc;
  assign dfy     = my - dzc;
  assign num_x   = {dfx, {MAGW{1'b0}}} - {{MAGW{1'b0}}, dfx};
  assign num_y   = {dfy, {MAGW{1'b0}}} - {{MAGW{1'b0}}, dfy};
  assign divisor = AXIS_FULL - dzc;

  assign ax_x = '{mode: mdx, val: x};
  assign ax_y = '{mode: mdy, val: y};

endmodule

### hw/rtl/grc_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage
module grc_div_lane (
  input  logic                       clk,
  input  logic [grc_pkg::DIV_STEPS:0] en,
  input  logic [grc_pkg::NUMW-1:0]   num,
  input  logic [grc_pkg::MAGW-1:0]   divisor,
  output logic [grc_pkg::MAGW-1:0]   quot
);
  import grc_pkg::*;

  // partial remainder, numerator low bits turning into quotient, divisor
  logic [MAGW-1:0] rem [DIV_STEPS+1];
  logic [MAGW-1:0] lo  [DIV_STEPS+1];
  logic [MAGW-1:0] d   [DIV_STEPS+1];
  logic [MAGW-1:0] rem_next [DIV_STEPS+1];
  logic [MAGW-1:0] lo_next  [DIV_STEPS+1];

  // one compare-subtract per stage
  always_comb begin
    logic [MAGW:0] t, df;
    logic          ge;
    rem_next[0] = num[NUMW-1:MAGW];
    lo_next[0]  = num[MAGW-1:0];
    for (int k = 1; k <= DIV_STEPS; k++) begin
      t           = {rem[k-1], lo[k-1][MAGW-1]};
      df          = t - {1'b0, d[k-1]};
      ge          = t >= {1'b0, d[k-1]};
      rem_next[k] = ge ? df[MAGW-1:0] : t[MAGW-1:0];
      lo_next[k]  = {lo[k-1][MAGW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) d[0] <= divisor;
    for (int k = 0; k <= DIV_STEPS; k++) begin
      if (en[k]) begin
        rem[k] <= rem_next[k];
        lo[k]  <= lo_next[k];
      end
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (en[k]) d[k] <= d[k-1];
    end
  end

  assign quot = lo[DIV_STEPS];

endmodule

### hw/rtl/gamepad_report_conditioner_unit.sv
// Top level of the gamepad report conditioner
//
// Input stream s_*: one controller report per transfer, four stick axes and
// sixteen button bits. Output stream m_*: one conditioned report per input
// report, in order. Configuration goes in through cfg_we/cfg_index/cfg_data,
// one register per cycle. Write it only while no report is in flight; the
// block itself does not enforce this. From input transfer to output valid,
// the transfer edge loads the front stage (inversion, deadzone decision,
// button remap), then fifteen divide stages that each produce one quotient
// bit of the rescale, then the output register.
// Throughput is one report per cycle while m_tready stays high; the divide
// pipeline sets the depth. Each stage holds when it is full and the stage
// after it cannot take its contents, so empty stages keep filling while the
// receiver stalls and s_tready only drops once every stage holds a report.
// Reset clears all valid bits, sets stick_flags and both deadzones to zero
// and the button map to the identity map.
module gamepad_report_conditioner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // left_x, left_y, right_x, right_y, buttons
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // out_left_x, out_left_y, out_right_x,
                                 // out_right_y, out_buttons
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import grc_pkg::*;
  `include "gamepad_report_conditioner_unit_assert.svh"

  logic [8:0]      flags;
  logic [MAGW-1:0] dz_l, dz_r;
  logic [59:0]     bmap;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      dz_l  <= '0;
      dz_r  <= '0;
      bmap  <= MAP_IDENTITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAGS: flags <= cfg_data[8:0];
        REG_DZ_L:  dz_l  <= cfg_data[MAGW-1:0];
        REG_DZ_R:  dz_r  <= cfg_data[MAGW-1:0];
        REG_MAP:   bmap  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // stage advance chain
  logic [PIPE_LAST:0]   vld;
  logic [PIPE_LAST+1:0] adv;

  always_comb begin
    adv[PIPE_LAST+1] = m_tready;
    for (int s = PIPE_LAST; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int s = 1; s <= PIPE_LAST; s++) begin
        if (adv[s]) vld[s] <= vld[s-1];
      end
    end
  end

  assign s_tready = adv[0];

  // axis inversion (Y inverted unless its bit is set)
  logic [AXW-1:0] lx, ly, rx, ry;
  assign lx = flags[F_INV_LX] ? ~s_tdata[15:0]  : s_tdata[15:0];
  assign ly = flags[F_INV_LY] ?  s_tdata[31:16] : ~s_tdata[31:16];
  assign rx = flags[F_INV_RX] ? ~s_tdata[47:32] : s_tdata[47:32];
  assign ry = flags[F_INV_RY] ?  s_tdata[63:48] : ~s_tdata[63:48];

  axis_info_t      ax [4];
  logic [NUMW-1:0] num [4];
  logic [MAGW-1:0] dv_l, dv_r;
  logic [MAGW-1:0] quot [4];

  grc_stick u_stick_l (
    .x(lx), .y(ly), .dz(dz_l), .radial(flags[F_RAD_L]), .scale(flags[F_SCL_L]),
    .ax_x(ax[0]), .ax_y(ax[1]), .num_x(num[0]), .num_y(num[1]), .divisor(dv_l)
  );

  grc_stick u_stick_r (
    .x(rx), .y(ry), .dz(dz_r), .radial(flags[F_RAD_R]), .scale(flags[F_SCL_R]),
    .ax_x(ax[2]), .ax_y(ax[3]), .num_x(num[2]), .num_y(num[3]), .divisor(dv_r)
  );

  // button remap
  logic [15:0] btn;
  always_comb begin
    logic [3:0] src, dst;
    src = '0;
    dst = '0;
    if (bmap == MAP_IDENTITY) begin
      btn = s_tdata[79:64];
    end else begin
      btn = '0;
      for (int i = 0; i < 15; i++) begin
        src = map_src(4'(i));
        dst = bmap[4*i +: 4];
        btn[dst] = btn[dst] | s_tdata[64 + int'(src)];
      end
    end
  end

  // divide lanes
  for (genvar a = 0; a < 4; a++) begin : g_lane
    grc_div_lane u_div (
      .clk(clk), .en(adv[DIV_STEPS:0]), .num(num[a]),
      .divisor((a < 2) ? dv_l : dv_r), .quot(quot[a])
    );
  end

  // sideband travels beside the divide lanes
  grc_side_t side [DIV_STEPS+1];
  grc_side_t side_in;

  always_comb begin
    for (int a = 0; a < 4; a++) side_in.ax[a] = ax[a];
    side_in.buttons = btn;
    side_in.swap    = flags[F_SWAP];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) side[0] <= side_in;
    for (int s = 1; s <= DIV_STEPS; s++) begin
      if (adv[s]) side[s] <= side[s-1];
    end
  end

  // result select, swap and output register
  logic [AXW-1:0] res [4];
  logic [79:0]    out_next;
  logic [79:0]    out_reg;

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      case (side[DIV_STEPS].ax[a].mode)
        AM_PASS:  res[a] = side[DIV_STEPS].ax[a].val;
        AM_ZERO:  res[a] = '0;
        AM_SCALE: res[a] = side[DIV_STEPS].ax[a].val[AXW-1] ? ~{1'b0, quot[a]}
                                                            : {1'b0, quot[a]};
        default:  res[a] = '0;
      endcase
    end
    if (side[DIV_STEPS].swap)
      out_next = {side[DIV_STEPS].buttons, res[1], res[0], res[3], res[2]};
    else
      out_next = {side[DIV_STEPS].buttons, res[3], res[2], res[1], res[0]};
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_LAST]) out_reg <= out_next;
  end

  assign m_tvalid = vld[PIPE_LAST];
  assign m_tdata  = out_reg;

  `GRC_ASSERT_IMP(a_empty_out_ready, clk, rst, !vld[PIPE_LAST], s_tready, "ready low with output empty")
  `GRC_ASSERT_IMP(a_sink_ready_src, clk, rst, m_tready, s_tready, "ready low while sink ready")
  `GRC_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "output valid after reset")

endmodule
